FILE: hw/rtl/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler package
// Shared constants, types and arithmetic helpers for the scaler datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Store geometry and target limits.
  localparam int MAX_SRC_WIDTH  = 64;
  localparam int MAX_SRC_HEIGHT = 64;
  localparam int MAX_DST_SIZE   = 4096;

  // Fixed field widths.
  localparam int FRAC_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int PIX_W      = CHAN_W * NUM_CHAN;
  localparam int POS_W      = 12;
  localparam int SRC_CFG_W  = 7;
  localparam int DST_CFG_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Source index widths and step width.
  localparam int XI_W        = (MAX_SRC_WIDTH > 2) ? $clog2(MAX_SRC_WIDTH) : 1;
  localparam int YI_W        = (MAX_SRC_HEIGHT > 2) ? $clog2(MAX_SRC_HEIGHT) : 1;
  localparam int MAX_SRC_DIM = (MAX_SRC_WIDTH > MAX_SRC_HEIGHT) ? MAX_SRC_WIDTH
                                                                 : MAX_SRC_HEIGHT;
  localparam int STEP_W      = $clog2((MAX_SRC_DIM - 1) * (1 << FRAC_W) + 1);
  localparam int PROD_W      = POS_W + STEP_W;
  localparam int DIV_CNT_W   = $clog2(STEP_W + 1);

  // Four banks split by column and row parity.
  localparam int NUM_BANKS  = 4;
  localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int XH_W       = (HALF_W > 1) ? $clog2(HALF_W) : 1;
  localparam int YH_W       = (HALF_H > 1) ? $clog2(HALF_H) : 1;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic [FRAC_W:0] ONE_FIXED = (FRAC_W + 1)'(1) << FRAC_W;

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_SOURCE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_SOURCE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_TARGET_WIDTH  = 2'd2;
  localparam cfg_idx_t REG_TARGET_HEIGHT = 2'd3;

  // Request codes.
  typedef enum logic {
    REQ_LOAD   = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_t;

  typedef logic [CHAN_W-1:0]    chan_t;
  typedef logic [FRAC_W-1:0]    frac_t;
  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [PIX_W-1:0]     pix_t;
  typedef logic [BANK_AW-1:0]   bank_addr_t;

  // The four neighbors of one channel.
  typedef struct packed {
    chan_t p00;
    chan_t p10;
    chan_t p01;
    chan_t p11;
  } quad_t;

  // Saturates a source size register to [2, hi].
  function automatic logic [SRC_CFG_W-1:0] clamp_src(logic [SRC_CFG_W-1:0] v, int hi);
    if (v < SRC_CFG_W'(2)) begin
      return SRC_CFG_W'(2);
    end
    if (int'(v) > hi) begin
      return SRC_CFG_W'(hi);
    end
    return v;
  endfunction

  // Saturates a target size register to [1, MAX_DST_SIZE].
  function automatic logic [DST_CFG_W-1:0] clamp_dst(logic [DST_CFG_W-1:0] v);
    if (v == '0) begin
      return DST_CFG_W'(1);
    end
    if (int'(v) > MAX_DST_SIZE) begin
      return DST_CFG_W'(MAX_DST_SIZE);
    end
    return v;
  endfunction

  // Saturates a target coordinate to the last column or row.
  function automatic logic [POS_W-1:0] clamp_pos(logic [POS_W-1:0] pos,
                                                 logic [DST_CFG_W-1:0] dst);
    logic [DST_CFG_W-1:0] last;
    last = dst - DST_CFG_W'(1);
    if (DST_CFG_W'(pos) >= dst) begin
      return last[POS_W-1:0];
    end
    return pos;
  endfunction

  // Linear blend with each weighted term floored separately.
  function automatic chan_t blend(chan_t a, chan_t b, frac_t f);
    logic [FRAC_W:0]        w;
    logic [CHAN_W+FRAC_W:0] ta;
    logic [CHAN_W+FRAC_W:0] tb;
    logic [CHAN_W+1:0]      sum;
    w   = ONE_FIXED - {1'b0, f};
    ta  = (CHAN_W + FRAC_W + 1)'(a) * (CHAN_W + FRAC_W + 1)'(w);
    tb  = (CHAN_W + FRAC_W + 1)'(b) * (CHAN_W + FRAC_W + 1)'(f);
    sum = (CHAN_W + 2)'(ta >> FRAC_W) + (CHAN_W + 2)'(tb >> FRAC_W);
    return sum[CHAN_W-1:0];
  endfunction

  // Word address inside one parity bank.
  function automatic bank_addr_t bank_addr(logic [XH_W-1:0] xh, logic [YH_W-1:0] yh);
    return BANK_AW'(int'(yh) * HALF_W + int'(xh));
  endfunction

endpackage

FILE: hw/rtl/bis_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/bis_step_div.sv
// ----------------------------------------------------------------------------
// Step divider
// Restoring divider that forms the 6.16 step (src - 1) * 65536 / dst,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bis_step_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [bis_pkg::SRC_CFG_W-1:0]     src,
  input  logic [bis_pkg::DST_CFG_W-1:0]     dst,
  output bis_pkg::step_t                    step,
  output logic                              busy
);
  import bis_pkg::*;

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEP_W-1:0]    dvd_r, dvd_nxt;
  logic [STEP_W-1:0]    quo_r, quo_nxt;
  logic [DST_CFG_W-1:0] den_r, den_nxt;
  logic [DST_CFG_W-1:0] rem_r, rem_nxt;
  logic [DST_CFG_W:0]   rem_sh;

  // One restoring step per cycle; a start reloads the operands.
  always_comb begin
    cnt_nxt = cnt_r;
    dvd_nxt = dvd_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    rem_nxt = rem_r;
    rem_sh  = {rem_r, dvd_r[STEP_W-1]};
    if (start) begin
      cnt_nxt = DIV_CNT_W'(STEP_W);
      dvd_nxt = STEP_W'(src - SRC_CFG_W'(1)) << FRAC_W;
      quo_nxt = '0;
      den_nxt = dst;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      dvd_nxt = dvd_r << 1;
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = DST_CFG_W'(rem_sh - {1'b0, den_r});
        quo_nxt = {quo_r[STEP_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DST_CFG_W-1:0];
        quo_nxt = {quo_r[STEP_W-2:0], 1'b0};
      end
    end
  end

  // Iteration counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign step = quo_r;
  assign busy = (cnt_r != '0);

endmodule

FILE: hw/rtl/bis_lane.sv
// ----------------------------------------------------------------------------
// Channel lane
// Two-stage bilinear blend of one color channel: horizontal pairs first,
// then between the two rows.
// ----------------------------------------------------------------------------
module bis_lane (
  input  logic            clk,
  input  bis_pkg::quad_t  quad,
  input  bis_pkg::frac_t  fx,
  input  bis_pkg::frac_t  fy,
  output bis_pkg::chan_t  chan
);
  import bis_pkg::*;

  chan_t top_r, top_nxt;
  chan_t bot_r, bot_nxt;
  frac_t fy_r;
  chan_t chan_r, chan_nxt;

  // Horizontal blends of the upper and lower pairs.
  always_comb begin
    top_nxt = blend(quad.p00, quad.p10, fx);
    bot_nxt = blend(quad.p01, quad.p11, fx);
  end

  // Vertical blend between the two rows.
  always_comb begin
    chan_nxt = blend(top_r, bot_r, fy_r);
  end

  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    bot_r  <= bot_nxt;
    fy_r   <= fy;
    chan_r <= chan_nxt;
  end

  assign chan = chan_r;

endmodule

FILE: hw/rtl/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Holds an RGBA source image and returns bilinearly scaled target pixels.
// ----------------------------------------------------------------------------
// Usage:
// An item is accepted at a clock edge where start is high and busy is low.
// A load item (in_req_type = 0) writes an in-range source pixel; no result.
// A sample item (in_req_type = 1) names a target column and row and gives one
// RGBA result, strobed by out_valid for a single cycle at the pipeline's end.
// One item is accepted every cycle while busy is low; loads and samples may be
// mixed freely and keep their order. The receiver cannot stall the block.
// The source image sits in four parity banks (even/odd column, even/odd row),
// so the four neighbors of a sample are read in one cycle, one per bank.
// Configuration writes take effect at once in the registers; the 6.16 steps
// are then recomputed by two restoring dividers, one bit per cycle, and busy
// stays high until both dividers finish after the last write. After reset the
// registers hold their defaults and busy is high until the dividers finish.
// Source pixels are undefined after reset until they are loaded.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
  input  logic                               clk,
  input  logic                               rst_n,
  // Item channel
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [bis_pkg::POS_W-1:0]          in_col,
  input  logic [bis_pkg::POS_W-1:0]          in_row,
  input  logic [bis_pkg::CHAN_W-1:0]         in_red_in,
  input  logic [bis_pkg::CHAN_W-1:0]         in_green_in,
  input  logic [bis_pkg::CHAN_W-1:0]         in_blue_in,
  input  logic [bis_pkg::CHAN_W-1:0]         in_alpha_in,
  // Result channel
  output logic                               out_valid,
  output logic [bis_pkg::CHAN_W-1:0]         out_red_out,
  output logic [bis_pkg::CHAN_W-1:0]         out_green_out,
  output logic [bis_pkg::CHAN_W-1:0]         out_blue_out,
  output logic [bis_pkg::CHAN_W-1:0]         out_alpha_out,
  // Configuration port
  input  logic                               cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bis_pkg::*;

  // Configuration registers.
  logic [SRC_CFG_W-1:0] src_width_r, src_width_nxt;
  logic [SRC_CFG_W-1:0] src_height_r, src_height_nxt;
  logic [DST_CFG_W-1:0] tgt_width_r, tgt_width_nxt;
  logic [DST_CFG_W-1:0] tgt_height_r, tgt_height_nxt;
  logic                 recalc_r, recalc_nxt;

  logic [SRC_CFG_W-1:0] src_w_c, src_h_c;
  logic [DST_CFG_W-1:0] tgt_w_c, tgt_h_c;
  step_t                step_x, step_y;
  logic                 div_x_busy, div_y_busy;
  logic                 accept;

  // Stage 1: accepted item.
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_smp_r, s1_smp_nxt;
  logic [POS_W-1:0]     s1_col_r, s1_col_nxt;
  logic [POS_W-1:0]     s1_row_r, s1_row_nxt;
  pix_t                 s1_pix_r;

  // Stage 2: source index and fraction.
  logic [PROD_W-1:0]    prod_x, prod_y;
  logic                 s2_smp_r, s2_smp_nxt;
  logic                 s2_wr_r, s2_wr_nxt;
  logic [XI_W-1:0]      s2_ix_r, s2_ix_nxt;
  logic [YI_W-1:0]      s2_iy_r, s2_iy_nxt;
  frac_t                s2_fx_r, s2_fy_r;
  pix_t                 s2_pix_r;
  logic [XI_W:0]        ix_inc;
  logic [YI_W:0]        iy_inc;
  logic [XH_W-1:0]      xe_half, xo_half;
  logic [YH_W-1:0]      ye_half, yo_half;

  // Stage 3: bank read data.
  pix_t                 bank_rd [NUM_BANKS];
  logic                 s3_smp_r;
  frac_t                s3_fx_r, s3_fy_r;
  logic                 s3_xp_r, s3_yp_r;
  pix_t                 rd00, rd10, rd01, rd11;
  quad_t                lane_quad [NUM_CHAN];
  chan_t                lane_chan [NUM_CHAN];

  // Stage 4 and output strobe.
  logic                 s4_smp_r;
  logic                 out_valid_r;

  assign accept = start && !busy;
  assign busy   = recalc_r || div_x_busy || div_y_busy;

  // Register writes; any write triggers a step recompute.
  always_comb begin
    src_width_nxt  = src_width_r;
    src_height_nxt = src_height_r;
    tgt_width_nxt  = tgt_width_r;
    tgt_height_nxt = tgt_height_r;
    recalc_nxt     = cfg_we;
    if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  src_width_nxt  = cfg_data[SRC_CFG_W-1:0];
        REG_SOURCE_HEIGHT: src_height_nxt = cfg_data[SRC_CFG_W-1:0];
        REG_TARGET_WIDTH:  tgt_width_nxt  = cfg_data[DST_CFG_W-1:0];
        REG_TARGET_HEIGHT: tgt_height_nxt = cfg_data[DST_CFG_W-1:0];
        default: begin
          src_width_nxt = src_width_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= SRC_CFG_W'(64);
      src_height_r <= SRC_CFG_W'(64);
      tgt_width_r  <= DST_CFG_W'(64);
      tgt_height_r <= DST_CFG_W'(64);
      recalc_r     <= 1'b1;
    end else begin
      src_width_r  <= src_width_nxt;
      src_height_r <= src_height_nxt;
      tgt_width_r  <= tgt_width_nxt;
      tgt_height_r <= tgt_height_nxt;
      recalc_r     <= recalc_nxt;
    end
  end

  // Saturated sizes.
  always_comb begin
    src_w_c = clamp_src(src_width_r, MAX_SRC_WIDTH);
    src_h_c = clamp_src(src_height_r, MAX_SRC_HEIGHT);
    tgt_w_c = clamp_dst(tgt_width_r);
    tgt_h_c = clamp_dst(tgt_height_r);
  end

  // Step dividers for both axes.
  bis_step_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc_r),
    .src   (src_w_c),
    .dst   (tgt_w_c),
    .step  (step_x),
    .busy  (div_x_busy)
  );

  bis_step_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (recalc_r),
    .src   (src_h_c),
    .dst   (tgt_h_c),
    .step  (step_y),
    .busy  (div_y_busy)
  );

  // Stage 1: take the item; sample coordinates are saturated to the target.
  always_comb begin
    s1_valid_nxt = accept;
    s1_smp_nxt   = (in_req_type == REQ_SAMPLE);
    if (in_req_type == REQ_SAMPLE) begin
      s1_col_nxt = clamp_pos(in_col, tgt_w_c);
      s1_row_nxt = clamp_pos(in_row, tgt_h_c);
    end else begin
      s1_col_nxt = in_col;
      s1_row_nxt = in_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_smp_r <= s1_smp_nxt;
    s1_col_r <= s1_col_nxt;
    s1_row_r <= s1_row_nxt;
    s1_pix_r <= {in_alpha_in, in_blue_in, in_green_in, in_red_in};
  end

  // Stage 2: position times step gives index and fraction.
  always_comb begin
    prod_x     = PROD_W'(s1_col_r) * PROD_W'(step_x);
    prod_y     = PROD_W'(s1_row_r) * PROD_W'(step_y);
    s2_smp_nxt = s1_valid_r && s1_smp_r;
    s2_wr_nxt  = s1_valid_r && !s1_smp_r
                 && (s1_col_r < POS_W'(MAX_SRC_WIDTH))
                 && (s1_row_r < POS_W'(MAX_SRC_HEIGHT));
    if (s1_smp_r) begin
      s2_ix_nxt = prod_x[FRAC_W +: XI_W];
      s2_iy_nxt = prod_y[FRAC_W +: YI_W];
    end else begin
      s2_ix_nxt = s1_col_r[XI_W-1:0];
      s2_iy_nxt = s1_row_r[YI_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_smp_r <= 1'b0;
      s2_wr_r  <= 1'b0;
    end else begin
      s2_smp_r <= s2_smp_nxt;
      s2_wr_r  <= s2_wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_ix_r  <= s2_ix_nxt;
    s2_iy_r  <= s2_iy_nxt;
    s2_fx_r  <= prod_x[FRAC_W-1:0];
    s2_fy_r  <= prod_y[FRAC_W-1:0];
    s2_pix_r <= s1_pix_r;
  end

  // Half indexes of the even and odd member of each neighbor pair.
  always_comb begin
    ix_inc  = {1'b0, s2_ix_r} + (XI_W + 1)'(1);
    iy_inc  = {1'b0, s2_iy_r} + (YI_W + 1)'(1);
    xe_half = XH_W'(ix_inc >> 1);
    xo_half = XH_W'(s2_ix_r >> 1);
    ye_half = YH_W'(iy_inc >> 1);
    yo_half = YH_W'(s2_iy_r >> 1);
  end

  // Parity banks: bit 0 of the bank number is column parity, bit 1 row parity.
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [XH_W-1:0] xh;
    logic [YH_W-1:0] yh;
    logic            we;
    bank_addr_t      addr;

    always_comb begin
      xh   = (((b % 2) == 0) && s2_smp_r) ? xe_half : xo_half;
      yh   = (((b / 2) == 0) && s2_smp_r) ? ye_half : yo_half;
      we   = s2_wr_r && (s2_ix_r[0] == 1'(b % 2)) && (s2_iy_r[0] == 1'(b / 2));
      addr = bank_addr(xh, yh);
    end

    bis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (addr),
      .wdata (s2_pix_r),
      .raddr (addr),
      .rdata (bank_rd[b])
    );
  end

  // Stage 3 control alongside the bank reads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_smp_r <= 1'b0;
    end else begin
      s3_smp_r <= s2_smp_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_fx_r <= s2_fx_r;
    s3_fy_r <= s2_fy_r;
    s3_xp_r <= s2_ix_r[0];
    s3_yp_r <= s2_iy_r[0];
  end

  // Route bank outputs to neighbor positions by the index parities.
  always_comb begin
    rd00 = bank_rd[{s3_yp_r, s3_xp_r}];
    rd10 = bank_rd[{s3_yp_r, !s3_xp_r}];
    rd01 = bank_rd[{!s3_yp_r, s3_xp_r}];
    rd11 = bank_rd[{!s3_yp_r, !s3_xp_r}];
  end

  // One blend lane per channel.
  for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
    assign lane_quad[k] = {rd00[k*CHAN_W +: CHAN_W], rd10[k*CHAN_W +: CHAN_W],
                           rd01[k*CHAN_W +: CHAN_W], rd11[k*CHAN_W +: CHAN_W]};

    bis_lane u_lane (
      .clk  (clk),
      .quad (lane_quad[k]),
      .fx   (s3_fx_r),
      .fy   (s3_fy_r),
      .chan (lane_chan[k])
    );
  end

  // Result strobe follows the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_smp_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s4_smp_r    <= s3_smp_r;
      out_valid_r <= s4_smp_r;
    end
  end

  // Merge the lane results into one pixel.
  assign out_valid     = out_valid_r;
  assign out_red_out   = lane_chan[0];
  assign out_green_out = lane_chan[1];
  assign out_blue_out  = lane_chan[2];
  assign out_alpha_out = lane_chan[3];

endmodule
